/* rtl/shared_pool_multi_stack_top_defines.svh */
// Assertion macros shared by the shared pool stack RTL.
`ifndef SHARED_POOL_MULTI_STACK_TOP_DEFINES_SVH
`define SHARED_POOL_MULTI_STACK_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sps_pkg.sv */
// Types and codes for the shared pool stack block.
`timescale 1ns / 1ps

package sps_pkg;

    localparam int CFG_W   = 4;
    localparam int SID_IW  = 3;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

    localparam logic [CFG_W-1:0] STACKS_IN_USE_RST = 4'd8;

    typedef struct packed {
        logic                     func;
        logic [SID_IW-1:0]        stack_id;
        logic signed [WORD_W-1:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] pop_value;
        logic [STAT_W-1:0]        status;
    } rsp_t;

endpackage

/* rtl/sps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/shared_pool_multi_stack_top.sv */
// Top level: several LIFO stacks sharing one slot pool with a linked free list.
`timescale 1ns / 1ps
`include "shared_pool_multi_stack_top_defines.svh"

// Usage:
//   Command channel: cmd (func, stack_id, push_value) is taken at a rising edge
//   with start high and busy low. Every command yields exactly one result beat.
//   Result channel: result (pop_value, status) is valid for one cycle while done
//   is high; the receiver cannot stall, so it must take the beat in that cycle.
//   Config channel: cfg_data sets stacks_in_use when cfg_valid and cfg_ready
//   are high; cfg_ready is always high. Write it only while the block is idle.
//   The accepting edge moves the state to S_EXEC; done and result are registered
//   out of S_EXEC, and the result beat is taken while done is high.
//   busy is high in S_EXEC, so no new command is taken there. The accept cycle reads
//   the stack top and issues the slot read; the next cycle consumes the registered
//   link and data words and writes the link and data RAMs back.
//   A new command may be taken in the cycle its predecessor's result is shown.
//   Reset: all stacks empty, free list starts at slot zero, stacks_in_use 8.
//   No clearing pass: a fill count marks slots never allocated, whose link is
//   implied as the next slot, so the block accepts commands right after reset.

module shared_pool_multi_stack_top #(
    parameter int MAX_STACKS = 8,
    parameter int NUM_SLOTS  = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  sps_pkg::cmd_t              cmd,
    output logic                       done,
    output sps_pkg::rsp_t              result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sps_pkg::CFG_W-1:0]  cfg_data
);

    import sps_pkg::*;

    localparam int AW     = $clog2(NUM_SLOTS);
    localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
    localparam int SID_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int SXW    = (SID_W > SID_IW) ? SID_W : SID_IW;
    localparam int EN_RAW = $clog2(MAX_STACKS + 1);
    localparam int EN_W   = (EN_RAW > CFG_W) ? EN_RAW : CFG_W;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_SLOTS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // control state
    logic              state_reg, state_next;
    logic              done_reg, done_next;
    logic [CFG_W-1:0]  siu_reg, siu_next;
    logic [PTR_W-1:0]  free_head_reg, free_head_next;
    logic [PTR_W-1:0]  fill_reg, fill_next;
    logic [PTR_W-1:0]  tops_reg [MAX_STACKS];

    // per-command payload held into the execute cycle
    logic              func_reg;
    logic [SID_W-1:0]  sid_reg;
    logic [PTR_W-1:0]  slot_reg;
    logic [PTR_W-1:0]  old_top_reg;
    logic [WORD_W-1:0] word_reg;
    logic [STAT_W-1:0] stat_reg;
    rsp_t              result_reg, result_next;

    logic              accept;
    logic [SXW-1:0]    sid_x;
    logic [SID_W-1:0]  sid_idx;
    logic [EN_W-1:0]   siu_x;
    logic [EN_W-1:0]   enabled;
    logic              bad_sid;
    logic [PTR_W-1:0]  top_sel;
    logic [PTR_W-1:0]  slot_sel;
    logic [STAT_W-1:0] stat_sel;

    logic              exec_ok;
    logic              fresh;
    logic              link_we;
    logic [PTR_W-1:0]  link_wdata;
    logic [PTR_W-1:0]  link_rdata;
    logic              data_we;
    logic [WORD_W-1:0] data_rdata;

    assign busy      = (state_reg == S_EXEC);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign sid_x   = SXW'(cmd.stack_id);
    assign sid_idx = sid_x[SID_W-1:0];
    assign siu_x   = EN_W'(siu_reg);
    assign enabled = (siu_x > EN_W'(MAX_STACKS)) ? EN_W'(MAX_STACKS) : siu_x;
    assign bad_sid = EN_W'(cmd.stack_id) >= enabled;
    assign top_sel = tops_reg[sid_idx];

    always_comb
    begin
        slot_sel = (cmd.func == FUNC_PUSH) ? free_head_reg : top_sel;
        if (bad_sid)
        begin
            stat_sel = ST_BAD;
        end
        else if (cmd.func == FUNC_PUSH)
        begin
            stat_sel = (free_head_reg == NULL_PTR) ? ST_FULL : ST_OK;
        end
        else
        begin
            stat_sel = (top_sel == NULL_PTR) ? ST_EMPTY : ST_OK;
        end
    end

    // slots at or above the fill count were never written; their link is slot+1
    assign exec_ok    = busy && (stat_reg == ST_OK);
    assign fresh      = (slot_reg == fill_reg);
    assign link_we    = exec_ok;
    assign link_wdata = (func_reg == FUNC_PUSH) ? old_top_reg : free_head_reg;
    assign data_we    = exec_ok && (func_reg == FUNC_PUSH);

    sps_ram #(
        .WIDTH (PTR_W),
        .DEPTH (NUM_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (slot_reg[AW-1:0]),
        .wdata (link_wdata),
        .raddr (slot_sel[AW-1:0]),
        .rdata (link_rdata)
    );

    sps_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (slot_reg[AW-1:0]),
        .wdata (word_reg),
        .raddr (slot_sel[AW-1:0]),
        .rdata (data_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        siu_next       = siu_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        result_next    = result_reg;

        if (cfg_valid && cfg_ready)
        begin
            siu_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next         = S_IDLE;
                done_next          = 1'b1;
                result_next.status = stat_reg;
                result_next.pop_value = '0;
                if (exec_ok)
                begin
                    if (func_reg == FUNC_PUSH)
                    begin
                        if (fresh)
                        begin
                            free_head_next = slot_reg + PTR_W'(1);
                            fill_next      = fill_reg + PTR_W'(1);
                        end
                        else
                        begin
                            free_head_next = link_rdata;
                        end
                    end
                    else
                    begin
                        free_head_next        = slot_reg;
                        result_next.pop_value = data_rdata;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            siu_reg       <= STACKS_IN_USE_RST;
            free_head_reg <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            siu_reg       <= siu_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                tops_reg[i] <= NULL_PTR;
            end
        end
        else if (exec_ok)
        begin
            tops_reg[sid_reg] <= (func_reg == FUNC_PUSH) ? slot_reg : link_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            func_reg    <= cmd.func;
            sid_reg     <= sid_idx;
            slot_reg    <= slot_sel;
            old_top_reg <= top_sel;
            word_reg    <= cmd.push_value;
            stat_reg    <= stat_sel;
        end
    end

    `SPS_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
    `SPS_ASSERT_NEXT(a_exec_done, busy, done, "execute cycle produced no result beat")
    `SPS_ASSERT_NEXT(a_done_gap, done, !done, "result beats closer than two cycles")
    `SPS_ASSERT_NOW(a_free_fill, free_head_reg != NULL_PTR, free_head_reg <= fill_reg,
        "free head beyond fill count")

endmodule

/* tb/shared_pool_multi_stack_top_tb.sv */
// Testbench for the shared pool multi-stack block: directed table plus random push/pop phases.
`timescale 1ns / 1ps

module shared_pool_multi_stack_top_tb;
    import sps_pkg::*;

    localparam int STACKS   = 8;
    localparam int SLOTS    = 256;
    localparam int DIR_ROWS = 25;
    localparam int PHASES   = 12;

    typedef enum logic {ROW_OP, ROW_CFG} row_kind_t;

    // One directed step: a command, or a stacks_in_use write (value holds the setting).
    // When fixed is set, st/popped are the expected beat; otherwise the pool model decides.
    typedef struct packed {
        row_kind_t         kind;
        logic              func;
        logic [SID_IW-1:0] sid;
        logic [WORD_W-1:0] value;
        logic              fixed;
        logic [STAT_W-1:0] st;
        logic [WORD_W-1:0] popped;
    } row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    cmd_t              cmd       = '0;
    logic              done;
    rsp_t              result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data  = '0;

    // Pool model state
    logic [8:0]        stack_top  [STACKS];
    logic [8:0]        slot_link  [SLOTS];
    logic [WORD_W-1:0] slot_word  [SLOTS];
    logic [8:0]        free_head;
    logic [CFG_W-1:0]  stacks_cfg;

    rsp_t owed_beats [$];
    rsp_t want_rsp;

    int errors    = 0;
    int n_cmds    = 0;
    int n_cfg     = 0;
    int n_ok      = 0;
    int n_full    = 0;
    int n_empty   = 0;
    int n_bad     = 0;

    row_t plan [DIR_ROWS] = '{
        '{ROW_CFG, FUNC_PUSH, 3'd0, 32'd8,         1'b0, ST_OK,    32'd0},
        '{ROW_OP,  FUNC_POP,  3'd0, 32'd0,         1'b1, ST_EMPTY, 32'd0},
        '{ROW_OP,  FUNC_POP,  3'd7, 32'd0,         1'b1, ST_EMPTY, 32'd0},
        '{ROW_OP,  FUNC_PUSH, 3'd0, 32'h7fffffff,  1'b1, ST_OK,    32'd0},
        '{ROW_OP,  FUNC_PUSH, 3'd0, 32'h80000000,  1'b1, ST_OK,    32'd0},
        '{ROW_OP,  FUNC_PUSH, 3'd7, 32'hffffffff,  1'b1, ST_OK,    32'd0},
        '{ROW_OP,  FUNC_PUSH, 3'd3, 32'h00000000,  1'b0, ST_OK,    32'd0},
        '{ROW_OP,  FUNC_POP,  3'd0, 32'd0,         1'b1, ST_OK,    32'h80000000},
        '{ROW_OP,  FUNC_POP,  3'd0, 32'd0,         1'b1, ST_OK,    32'h7fffffff},
        '{ROW_OP,  FUNC_POP,  3'd0, 32'd0,         1'b1, ST_EMPTY, 32'd0},
        '{ROW_OP,  FUNC_PUSH, 3'd1, 32'ha5a5a5a5,  1'b0, ST_OK,    32'd0},
        '{ROW_OP,  FUNC_PUSH, 3'd1, 32'h5a5a5a5a,  1'b0, ST_OK,    32'd0},
        '{ROW_CFG, FUNC_PUSH, 3'd0, 32'd2,         1'b0, ST_OK,    32'd0},
        '{ROW_OP,  FUNC_PUSH, 3'd3, 32'h12345678,  1'b1, ST_BAD,   32'd0},
        '{ROW_OP,  FUNC_POP,  3'd7, 32'd0,         1'b1, ST_BAD,   32'd0},
        '{ROW_OP,  FUNC_POP,  3'd1, 32'd0,         1'b0, ST_OK,    32'd0},
        '{ROW_CFG, FUNC_PUSH, 3'd0, 32'd0,         1'b0, ST_OK,    32'd0},
        '{ROW_OP,  FUNC_PUSH, 3'd0, 32'h0badcafe,  1'b1, ST_BAD,   32'd0},
        '{ROW_OP,  FUNC_POP,  3'd0, 32'd0,         1'b1, ST_BAD,   32'd0},
        '{ROW_CFG, FUNC_PUSH, 3'd0, 32'd15,        1'b0, ST_OK,    32'd0},
        '{ROW_OP,  FUNC_POP,  3'd7, 32'd0,         1'b1, ST_OK,    32'hffffffff},
        '{ROW_OP,  FUNC_POP,  3'd3, 32'd0,         1'b0, ST_OK,    32'd0},
        '{ROW_OP,  FUNC_POP,  3'd1, 32'd0,         1'b0, ST_OK,    32'd0},
        '{ROW_OP,  FUNC_PUSH, 3'd6, 32'hdeadbeef,  1'b0, ST_OK,    32'd0},
        '{ROW_OP,  FUNC_POP,  3'd6, 32'd0,         1'b0, ST_OK,    32'd0}
    };

    // Random phases: setting, push percentage, command count.
    // The 95% push phases run the pool dry; the 5-10% ones drain it again.
    int phase_cfg  [PHASES] = '{8, 1, 4, 15, 9, 0, 3, 8, 7, 12, 2, 8};
    int phase_push [PHASES] = '{60, 50, 95, 90, 10, 50, 70, 5, 95, 50, 30, 50};
    int phase_len  [PHASES] = '{120, 60, 300, 150, 200, 20, 80, 150, 200, 80, 60, 80};

    logic [WORD_W-1:0] extreme_words [4] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};

    shared_pool_multi_stack_top #(
        .MAX_STACKS (STACKS),
        .NUM_SLOTS  (SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic rsp_t apply_stack_op(input cmd_t c);
        rsp_t       r;
        logic [8:0] slot;
        int         enabled;
        r.pop_value = '0;
        r.status    = ST_OK;
        enabled     = (stacks_cfg > STACKS) ? STACKS : int'(stacks_cfg);
        if (int'(c.stack_id) >= enabled)
        begin
            r.status = ST_BAD;
        end
        else if (c.func == FUNC_PUSH)
        begin
            slot = free_head;
            if (slot >= SLOTS)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                free_head             = slot_link[slot];
                slot_word[slot]       = c.push_value;
                slot_link[slot]       = stack_top[c.stack_id];
                stack_top[c.stack_id] = slot;
            end
        end
        else
        begin
            slot = stack_top[c.stack_id];
            if (slot >= SLOTS)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.pop_value           = slot_word[slot];
                stack_top[c.stack_id] = slot_link[slot];
                slot_link[slot]       = free_head;
                free_head             = slot;
            end
        end
        return r;
    endfunction

    task automatic flag(input string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Leaves start high on return, so a zero gap keeps the next command back to back.
    task automatic issue(input cmd_t c, input int gap, input bit fixed, input rsp_t typed);
        rsp_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        predicted = apply_stack_op(c);
        owed_beats.insert(owed_beats.size(), fixed ? typed : predicted);
        n_cmds++;
    endtask

    task automatic write_stacks_in_use(input logic [CFG_W-1:0] v);
        start <= 1'b0;
        while (owed_beats.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        stacks_cfg = v;
        n_cfg++;
    endtask

    // Result beats: one cycle each, no backpressure.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            case (result.status)
                ST_OK:    n_ok++;
                ST_FULL:  n_full++;
                ST_EMPTY: n_empty++;
                default:  n_bad++;
            endcase
            if (owed_beats.size() == 0)
            begin
                flag($sformatf("unexpected beat: pop_value %h status %0d",
                               result.pop_value, result.status));
            end
            else
            begin
                want_rsp = owed_beats.pop_front();
                if (result.pop_value !== want_rsp.pop_value || result.status !== want_rsp.status)
                    flag($sformatf("beat wrong: pop_value %h (exp %h) status %0d (exp %0d)",
                                   result.pop_value, want_rsp.pop_value,
                                   result.status, want_rsp.status));
            end
        end
    end

    initial
    begin
        cmd_t c;
        rsp_t typed;
        row_t r;
        int   enabled;
        bit   steady;

        for (int i = 0; i < STACKS; i++)
            stack_top[i] = 9'(SLOTS);
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_link[i] = 9'(i + 1);
            slot_word[i] = '0;
        end
        free_head  = '0;
        stacks_cfg = STACKS_IN_USE_RST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            r = plan[i];
            if (r.kind == ROW_CFG)
            begin
                write_stacks_in_use(r.value[CFG_W-1:0]);
            end
            else
            begin
                c.func          = r.func;
                c.stack_id      = r.sid;
                c.push_value    = r.value;
                typed.pop_value = r.popped;
                typed.status    = r.st;
                issue(c, $urandom_range(0, 9), r.fixed, typed);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_stacks_in_use(CFG_W'(phase_cfg[p]));
            enabled = (phase_cfg[p] > STACKS) ? STACKS : phase_cfg[p];
            steady  = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len[p]; k++)
            begin
                c.func = ($urandom_range(0, 99) < phase_push[p]) ? FUNC_PUSH : FUNC_POP;
                if (enabled == 0 || $urandom_range(0, 9) == 0)
                    c.stack_id = SID_IW'($urandom_range(0, STACKS - 1));
                else
                    c.stack_id = SID_IW'($urandom_range(0, enabled - 1));
                if ($urandom_range(0, 15) == 0)
                    c.push_value = extreme_words[$urandom_range(0, 3)];
                else
                    c.push_value = $urandom();
                issue(c, steady ? 0 : $urandom_range(0, 9), 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (owed_beats.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (owed_beats.size() != 0)
            flag("beats still owed at end of run");

        $display("Ran %0d commands over %0d stacks_in_use settings, %0d errors",
                 n_cmds, n_cfg, errors);
        $display("Status seen: ok %0d, pool full %0d, stack empty %0d, bad stack %0d",
                 n_ok, n_full, n_empty, n_bad);
        if (errors == 0)
            $display("shared_pool_multi_stack_top: match");
        else
            $display("shared_pool_multi_stack_top: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("shared_pool_multi_stack_top: mismatch");
        $finish;
    end

endmodule
